// ----- sv/ecrc_pkg.sv -----
// ecrc_pkg: shared types, constants and helper functions for the euler channel rotation composer
// no dependencies
`default_nettype none
package ecrc_pkg;

    localparam int CORDIC_STEPS_DEF = 18;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ONE_Q16          = 65536;
    localparam int FULL_TURN        = 92160;
    localparam int HALF_TURN        = 46080;
    localparam int QUARTER_TURN     = 23040;
    localparam int GAIN_Q30         = 652032874;
    localparam int TURN_OFFSET      = 92 * FULL_TURN;

    localparam logic [2:0] KIND_X_ROT = 3'd3;
    localparam logic [2:0] KIND_Y_ROT = 3'd4;
    localparam logic [2:0] KIND_Z_ROT = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MAT,
        ST_EMIT
    } ecrc_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_FOLD,
        CS_ITER,
        CS_DONE
    } cordic_state_t;

    typedef struct packed {
        logic               valid;
        logic signed [17:0] sin_q16;
        logic signed [17:0] cos_q16;
    } trig_t;

    function automatic logic [21:0] atan_deg_q16(input logic [4:0] idx);
        logic [21:0] v;
        begin
            unique case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    // clamp to [-1.0, +1.0] in q2.16
    function automatic logic signed [17:0] sat_q16(input logic signed [39:0] v);
        logic signed [17:0] r;
        begin
            if (v > 40'sd65536)
                r = 18'sd65536;
            else if (v < -40'sd65536)
                r = -18'sd65536;
            else
                r = v[17:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/ecrc_cordic.sv -----
// ecrc_cordic: iterative sine and cosine of an angle in 1/256 degree, q2.16 results
// depends on ecrc_pkg
`default_nettype none
module ecrc_cordic #(
    parameter int STEPS = ecrc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [23:0] angle,
    output ecrc_pkg::trig_t         trig
);
    import ecrc_pkg::*;

    localparam int IW = $clog2(STEPS);

    cordic_state_t      cs_reg, cs_next;
    logic [2:0]         cnt_reg;
    logic [24:0]        rem_reg;
    logic               neg_reg;
    logic signed [25:0] z_reg;
    logic signed [32:0] x_reg, y_reg;
    logic [IW-1:0]      i_reg;

    logic [24:0]        sub_val;
    logic signed [17:0] r0, r1, r2;
    logic               fold_neg;
    logic signed [32:0] dx, dy;
    logic signed [25:0] atan_ext;
    logic signed [32:0] xr, yr;
    logic signed [17:0] cs_cos, cs_sin;

    always_comb
    begin
        cs_next = cs_reg;
        unique case (cs_reg)
            CS_IDLE:   if (start) cs_next = CS_REDUCE;
            CS_REDUCE: if (cnt_reg == 3'd0) cs_next = CS_FOLD;
            CS_FOLD:   cs_next = CS_ITER;
            CS_ITER:   if (i_reg == IW'(STEPS - 1)) cs_next = CS_DONE;
            CS_DONE:   cs_next = CS_IDLE;
            default:   cs_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cs_reg <= CS_IDLE;
        else
            cs_reg <= cs_next;
    end

    always_comb
    begin
        sub_val  = 25'(FULL_TURN) << cnt_reg;
        r0       = {1'b0, rem_reg[16:0]};
        r1       = (r0 > 18'sd46080) ? r0 - 18'sd92160 : r0;
        fold_neg = 1'b0;
        r2       = r1;
        if (r1 > 18'(QUARTER_TURN))
        begin
            r2       = r1 - 18'(HALF_TURN);
            fold_neg = 1'b1;
        end
        else if (r1 < -18'sd23040)
        begin
            r2       = r1 + 18'(HALF_TURN);
            fold_neg = 1'b1;
        end
        dx       = y_reg >>> i_reg;
        dy       = x_reg >>> i_reg;
        atan_ext = 26'(signed'({1'b0, atan_deg_q16(5'(i_reg))}));
    end

    always_ff @(posedge clk)
    begin
        unique case (cs_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    rem_reg <= {angle[23], angle} + 25'(TURN_OFFSET);
                    cnt_reg <= 3'd7;
                end
            end
            CS_REDUCE:
            begin
                if (rem_reg >= sub_val)
                    rem_reg <= rem_reg - sub_val;
                cnt_reg <= cnt_reg - 3'd1;
            end
            CS_FOLD:
            begin
                neg_reg <= fold_neg;
                z_reg   <= {r2, 8'b0};
                x_reg   <= 33'(GAIN_Q30);
                y_reg   <= '0;
                i_reg   <= '0;
            end
            CS_ITER:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_ext;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_ext;
                end
                i_reg <= i_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        xr     = (x_reg + 33'sd8192) >>> 14;
        yr     = (y_reg + 33'sd8192) >>> 14;
        cs_cos = sat_q16(40'(xr));
        cs_sin = sat_q16(40'(yr));
        trig.valid   = (cs_reg == CS_DONE);
        trig.cos_q16 = neg_reg ? -cs_cos : cs_cos;
        trig.sin_q16 = neg_reg ? -cs_sin : cs_sin;
    end

endmodule
`default_nettype wire

// ----- sv/euler_channel_rotation_composer.sv -----
// euler_channel_rotation_composer: running 3x3 rotation matrix over a joint's channels
// rotation channels use ecrc_cordic for sine and cosine and one shared 18x18 multiplier
// depends on ecrc_pkg and ecrc_cordic
// position channel: the block stays idle and ready unless it is last; when last it goes
// to the emit state, which registers the word and then returns to idle
// rotation channel: from accept the cordic runs reduce (8 steps), fold, its iterations
// and done, then the block runs 13 matrix steps with 12 products through the single
// multiplier and returns to idle, or emits the word first when last; the input is not
// ready until then; one word at a time, a held output word stalls the emit
// reset: matrix returns to identity, output empty, block idle
`default_nettype none
module euler_channel_rotation_composer #(
    parameter int CORDIC_STEPS = ecrc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,  // angle
    input  wire logic [2:0]   s_axis_tuser,  // channel_kind
    input  wire logic         s_axis_tlast,  // last_channel
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [167:0]      m_axis_tdata   // m00 m01 m02 m10 m11 m12 m20 m21 m22, 18 bits each
);
    import ecrc_pkg::*;

    ecrc_state_t        st_reg, st_next;
    logic [2:0]         kind_reg;
    logic               last_reg;
    logic signed [17:0] sin_reg, cos_reg;
    logic [3:0]         step_reg;
    logic signed [35:0] p_reg, acc_reg;
    logic signed [17:0] mat_reg [9];
    logic               out_valid_reg;
    logic [167:0]       out_data_reg;

    trig_t              trig;
    logic               accept, is_rot, emit_fire;
    logic [1:0]         col_a, col_b;
    logic [1:0]         t_cur, t_prev;
    logic [3:0]         j_prev;
    logic [3:0]         rd_idx, wr_idx;
    logic signed [17:0] ent, trig_op;
    logic signed [36:0] sum;
    logic signed [36:0] sum_rnd;
    logic signed [17:0] new_val;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign is_rot = (s_axis_tuser == KIND_X_ROT) || (s_axis_tuser == KIND_Y_ROT)
                 || (s_axis_tuser == KIND_Z_ROT);

    ecrc_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .start(accept && is_rot),
        .angle(s_axis_tdata),
        .trig (trig)
    );

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_rot)
                        st_next = ST_TRIG;
                    else if (s_axis_tlast)
                        st_next = ST_EMIT;
                end
            end
            ST_TRIG: if (trig.valid) st_next = ST_MAT;
            ST_MAT:  if (step_reg == 4'd12) st_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (!out_valid_reg || m_axis_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (st_reg == ST_IDLE);
        emit_fire     = (st_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    // column pair mixed by each rotation
    always_comb
    begin
        unique case (kind_reg)
            KIND_X_ROT:
            begin
                col_a = 2'd1;
                col_b = 2'd2;
            end
            KIND_Y_ROT:
            begin
                col_a = 2'd2;
                col_b = 2'd0;
            end
            default:
            begin
                col_a = 2'd0;
                col_b = 2'd1;
            end
        endcase
    end

    // per row: ma*c, mb*s, ma*s, mb*c
    always_comb
    begin
        t_cur   = step_reg[1:0];
        rd_idx  = 4'({2'b0, step_reg[3:2]} * 4'd3)
                + {2'b0, ((t_cur == 2'd0) || (t_cur == 2'd2)) ? col_a : col_b};
        ent     = (rd_idx < 4'd9) ? mat_reg[rd_idx] : 18'sd0;
        trig_op = ((t_cur == 2'd0) || (t_cur == 2'd3)) ? cos_reg : sin_reg;
        j_prev  = step_reg - 4'd1;
        t_prev  = j_prev[1:0];
        wr_idx  = 4'({2'b0, j_prev[3:2]} * 4'd3)
                + {2'b0, (t_prev == 2'd1) ? col_a : col_b};
        sum     = (t_prev == 2'd1) ? 37'(acc_reg) + 37'(p_reg) : 37'(p_reg) - 37'(acc_reg);
        sum_rnd = (sum + 37'sd32768) >>> 16;
        new_val = sat_q16(40'(sum_rnd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if ((st_reg == ST_MAT) && (step_reg != 4'd12))
            step_reg <= step_reg + 4'd1;
        else
            step_reg <= '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
        if (trig.valid)
        begin
            sin_reg <= trig.sin_q16;
            cos_reg <= trig.cos_q16;
        end
        if (st_reg == ST_MAT)
        begin
            if (step_reg < 4'd12)
                p_reg <= ent * trig_op;
            if ((step_reg != 4'd0) && ((t_prev == 2'd0) || (t_prev == 2'd2)))
                acc_reg <= p_reg;
        end
        if (emit_fire)
            out_data_reg <= {6'b0, mat_reg[8], mat_reg[7], mat_reg[6], mat_reg[5], mat_reg[4],
                             mat_reg[3], mat_reg[2], mat_reg[1], mat_reg[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                mat_reg[k] <= (k % 4 == 0) ? 18'(ONE_Q16) : 18'sd0;
        end
        else if (emit_fire)
        begin
            for (int k = 0; k < 9; k++)
                mat_reg[k] <= (k % 4 == 0) ? 18'(ONE_Q16) : 18'sd0;
        end
        else if ((st_reg == ST_MAT) && (step_reg != 4'd0)
                 && ((t_prev == 2'd1) || (t_prev == 2'd3)))
        begin
            mat_reg[wr_idx] <= new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 4'd12) else $error("matrix step out of range");

    a_trig_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        trig.valid |-> (st_reg == ST_TRIG)) else $error("cordic result outside wait");

    a_identity_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (mat_reg[0] == 18'sd65536) && (mat_reg[4] == 18'sd65536)
                      && (mat_reg[1] == 18'sd0)) else $error("matrix not reset after emit");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> m_axis_tvalid) else $error("emitted word lost");

endmodule
`default_nettype wire
